// ----- design/channel_blend_modes_defines.svh -----
// ----------------------------------------------------------------------------
// channel_blend_modes_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef CHANNEL_BLEND_MODES_DEFINES_SVH
`define CHANNEL_BLEND_MODES_DEFINES_SVH

// property checked only out of reset
`define CBM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("channel_blend_modes check failed");

// property checked at every edge, reset included
`define CBM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("channel_blend_modes check failed");

`endif

// ----- design/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// types, codes and helpers of the channel blend block
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int CFG_IDX_W   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_FACTOR = CFG_IDX_W'(1);

    localparam logic [7:0] MAX_LEVEL  = 8'd255;
    localparam logic [7:0] HALF_LEVEL = 8'd127;
    localparam logic [7:0] MIX_RESET  = 8'd255;

    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_DARKEN     = 4'd1,
        MODE_LIGHTEN    = 4'd2,
        MODE_MULTIPLY   = 4'd3,
        MODE_SCREEN     = 4'd4,
        MODE_OVERLAY    = 4'd5,
        MODE_HARDLIGHT  = 4'd6,
        MODE_SOFTLIGHT  = 4'd7,
        MODE_DIFFERENCE = 4'd8,
        MODE_DODGE      = 4'd9,
        MODE_BURN       = 4'd10
    } blend_mode_t;

    // classified item between front and back
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] div_x;
        logic [7:0] div_d;
        logic       div_big;
    } front_item_t;

    // product and divider stages of the back
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] ab;
        logic [7:0] inv;
        logic [7:0] aa;
        logic [7:0] aab;
        logic [7:0] div_d;
        logic       div_big;
        logic [7:0] rem;
        logic [7:0] quo;
    } back_work_t;

    // one restoring divide step: {quotient bit, new remainder}
    function automatic logic [8:0] div_step(logic [7:0] rem, logic [7:0] d);
        logic [8:0] t;
        logic [8:0] diff;
        t    = {rem, 1'b0};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, diff[7:0]};
        end
        return {1'b0, t[7:0]};
    endfunction

endpackage

// ----- design/cbm_front.sv -----
// ----------------------------------------------------------------------------
// cbm_front
// input stage: takes an item and sets up the divider operands for the mode
// ----------------------------------------------------------------------------
module cbm_front
    import cbm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  blend_mode_t  blend_mode,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   in_a,
    input  logic [7:0]   in_b,
    output logic         out_valid,
    input  logic         out_ready,
    output front_item_t  out_item
);

    logic        vld_reg;
    logic        vld_next;
    front_item_t item_reg;
    front_item_t item_next;
    logic        take;

    assign in_ready  = !vld_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next.a = in_a;
        item_next.b = in_b;
        unique case (blend_mode)
            MODE_DODGE: begin
                item_next.div_x = in_a;
                item_next.div_d = ~in_b;
            end
            MODE_BURN: begin
                item_next.div_x = ~in_a;
                item_next.div_d = in_b;
            end
            default: begin
                item_next.div_x = 8'd0;
                item_next.div_d = 8'd1;
            end
        endcase
        // quotient would reach 256: result clamps, zero divisor included
        item_next.div_big = (item_next.div_x >= item_next.div_d);
    end

    always_comb begin
        if (take) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- design/cbm_queue.sv -----
// ----------------------------------------------------------------------------
// cbm_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module cbm_queue
    import cbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output front_item_t out_item
);

    front_item_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;
    logic                   push;
    logic                   pop;

    assign in_ready  = (count_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- design/cbm_back.sv -----
// ----------------------------------------------------------------------------
// cbm_back
// execution pipeline: products, pipelined divider, mode select, mix and clamp
// ----------------------------------------------------------------------------
module cbm_back
    import cbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  blend_mode_t blend_mode,
    input  logic [7:0]  mix_factor,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_value
);

    logic [7:1] vld_reg;
    logic [7:1] vld_next;
    logic [7:1] feed;
    logic [8:1] adv;

    back_work_t work_reg [1:5];
    back_work_t work_next [1:5];

    logic signed [19:0] prod_r_reg;
    logic signed [19:0] prod_r_next;
    logic [15:0]        prod_a_reg;
    logic [15:0]        prod_a_next;
    logic [7:0]         out_reg;
    logic [7:0]         out_next;

    logic [15:0]        p_ab;
    logic [15:0]        p_inv;
    logic [15:0]        p_aa;
    logic [15:0]        p_aab;
    logic [10:0]        r_mode;
    logic signed [8:0]  f_s;
    logic [7:0]         inv_mix;
    logic [7:0]         diff;
    logic signed [19:0] sum;

    // stall chain: a stage loads when empty or when the next one moves
    always_comb begin
        adv[8] = out_ready;
        for (int k = 7; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        feed = {vld_reg[6:1], in_valid};
        for (int k = 1; k <= 7; k++) begin
            vld_next[k] = adv[k] ? feed[k] : vld_reg[k];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[7];
    assign out_value = out_reg;

    // stage 1: first products, divider setup
    // stages 2 to 5: two quotient bits each, second product in stage 2
    always_comb begin
        logic [8:0] s0;
        logic [8:0] s1;
        p_ab  = {8'd0, in_item.a} * {8'd0, in_item.b};
        p_inv = {8'd0, ~in_item.a} * {8'd0, ~in_item.b};
        p_aa  = {8'd0, in_item.a} * {8'd0, in_item.a};
        work_next[1].a       = in_item.a;
        work_next[1].b       = in_item.b;
        work_next[1].ab      = p_ab[15:8];
        work_next[1].inv     = p_inv[15:8];
        work_next[1].aa      = p_aa[15:8];
        work_next[1].aab     = 8'd0;
        work_next[1].div_d   = in_item.div_d;
        work_next[1].div_big = in_item.div_big;
        work_next[1].rem     = in_item.div_x;
        work_next[1].quo     = 8'd0;
        for (int k = 2; k <= 5; k++) begin
            work_next[k] = work_reg[k-1];
            s0 = div_step(work_reg[k-1].rem, work_reg[k-1].div_d);
            s1 = div_step(s0[7:0], work_reg[k-1].div_d);
            work_next[k].rem = s1[7:0];
            work_next[k].quo = {work_reg[k-1].quo[5:0], s0[8], s1[8]};
        end
        p_aab = {8'd0, work_reg[1].a} * {8'd0, work_reg[1].ab};
        work_next[2].aab = p_aab[15:8];
    end

    // stage 6: mode result and mix products
    always_comb begin
        back_work_t w;
        w = work_reg[5];
        diff = (w.a > w.b) ? (w.a - w.b) : (w.b - w.a);
        unique case (blend_mode)
            MODE_NORMAL:     r_mode = {3'd0, w.b};
            MODE_DARKEN:     r_mode = {3'd0, (w.a < w.b) ? w.a : w.b};
            MODE_LIGHTEN:    r_mode = {3'd0, (w.a > w.b) ? w.a : w.b};
            MODE_MULTIPLY:   r_mode = {3'd0, w.ab};
            MODE_SCREEN:     r_mode = {3'd0, MAX_LEVEL - w.inv};
            MODE_OVERLAY:    r_mode = (w.a < HALF_LEVEL) ? {2'd0, w.ab, 1'b0}
                                    : {3'd0, MAX_LEVEL} - {2'd0, w.inv, 1'b0};
            MODE_HARDLIGHT:  r_mode = (w.b < HALF_LEVEL) ? {2'd0, w.ab, 1'b0}
                                    : {3'd0, MAX_LEVEL} - {2'd0, w.inv, 1'b0};
            MODE_SOFTLIGHT:  r_mode = {2'd0, w.ab, 1'b0} + {3'd0, w.aa}
                                    - {2'd0, w.aab, 1'b0};
            MODE_DIFFERENCE: r_mode = {3'd0, diff};
            MODE_DODGE:      r_mode = {3'd0, w.div_big ? MAX_LEVEL : w.quo};
            MODE_BURN:       r_mode = {3'd0, w.div_big ? 8'd0 : ~w.quo};
            default:         r_mode = 11'd0;
        endcase
        f_s         = $signed({1'b0, mix_factor});
        inv_mix     = ~mix_factor;
        prod_r_next = 20'($signed(r_mode)) * 20'(f_s);
        prod_a_next = {8'd0, inv_mix} * {8'd0, w.a};
    end

    // stage 7: sum, floor by 256, saturate
    always_comb begin
        sum = prod_r_reg + $signed({4'd0, prod_a_reg});
        if (sum[19]) begin
            out_next = 8'd0;
        end else if (|sum[18:16]) begin
            out_next = MAX_LEVEL;
        end else begin
            out_next = sum[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= 5; k++) begin
            if (adv[k]) begin
                work_reg[k] <= work_next[k];
            end
        end
        if (adv[6]) begin
            prod_r_reg <= prod_r_next;
            prod_a_reg <= prod_a_next;
        end
        if (adv[7]) begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- design/channel_blend_modes.sv -----
// ----------------------------------------------------------------------------
// channel_blend_modes
// blends a base and a layer channel value by one of eleven rules, then mixes
// the rule result with the base value by a configured factor
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata[15:0]: base_value, layer_value
// m_       out  m_tvalid/m_tready  m_tdata[7:0]:  blended_value
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item per cycle while m_tready is high; path: front register, queue, 7-stage back
// the back's divider resolves two quotient bits per stage over four stages
// reset is synchronous on aresetn; mode resets to normal, mix to 255
// a stalled m_ side holds its item, fills the back, then the 4-entry queue,
// then the front drops s_tready
// cfg_ready is always high
// ----------------------------------------------------------------------------
module channel_blend_modes
    import cbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // base_value, layer_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // blended_value
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    blend_mode_t blend_mode_reg;
    blend_mode_t blend_mode_next;
    logic [7:0]  mix_factor_reg;
    logic [7:0]  mix_factor_next;

    logic        f_valid;
    logic        f_ready;
    front_item_t f_item;
    logic        q_valid;
    logic        q_ready;
    front_item_t q_item;

    assign cfg_ready = 1'b1;

    always_comb begin
        blend_mode_next = blend_mode_reg;
        mix_factor_next = mix_factor_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_BLEND_MODE) begin
                blend_mode_next = blend_mode_t'(cfg_data[3:0]);
            end else if (cfg_index == CFG_MIX_FACTOR) begin
                mix_factor_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_mode_reg <= MODE_NORMAL;
            mix_factor_reg <= MIX_RESET;
        end else begin
            blend_mode_reg <= blend_mode_next;
            mix_factor_reg <= mix_factor_next;
        end
    end

    cbm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .blend_mode (blend_mode_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_a       (s_tdata[7:0]),
        .in_b       (s_tdata[15:8]),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_item   (f_item)
    );

    cbm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    cbm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .blend_mode (blend_mode_reg),
        .mix_factor (mix_factor_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (m_tdata)
    );

endmodule

// ----- design/cbm_checker.sv -----
// ----------------------------------------------------------------------------
// cbm_checker
// port-level checks of the channel blend block
// ----------------------------------------------------------------------------
`include "channel_blend_modes_defines.svh"

module cbm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // pipeline empties on reset
    `CBM_ASSERT_ALWAYS(a_reset_no_output, aclk, !aresetn |=> !m_tvalid)
    // front register empty after reset, so input is open
    `CBM_ASSERT_ALWAYS(a_reset_input_open, aclk, !aresetn |=> s_tready)
    `CBM_ASSERT_ALWAYS(a_cfg_always_taken, aclk, cfg_valid |-> cfg_ready)
    `CBM_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `CBM_ASSERT(a_out_stable, aclk, aresetn,
        m_tvalid && !m_tready |=> $stable(m_tdata))

endmodule

bind channel_blend_modes cbm_checker u_cbm_checker (.*);
